// File: src/psd_pkg.sv
// Shared types and constants for the polygon signed distance block.
`default_nettype none
package psd_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int FRAC_W      = 16;
   localparam int T_W         = FRAC_W + 1;
   localparam int OFFP_W      = DIFF_W + T_W + 1;
   localparam int OFF_W       = OFFP_W - FRAC_W;
   localparam int D_W         = COORD_WIDTH + 2;
   localparam int SQ_W        = 2 * D_W;
   localparam int ROOT_W      = D_W;
   localparam int DIST_W      = 18;
   localparam int CNT_W       = 5;
   localparam int DIV_STEPS   = FRAC_W;
   localparam int ROOT_STEPS  = ROOT_W;

   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_T,
      ST_DIV,
      ST_OFFMUL,
      ST_DIST,
      ST_SQ,
      ST_ACC,
      ST_RINIT,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic rd;
      logic st_diff;
      logic st_mul;
      logic st_sum;
      logic st_t;
      logic div_step;
      logic st_off;
      logic st_d;
      logic st_sq;
      logic st_acc;
      logic first;
      logic sqrt_init;
      logic sqrt_step;
      logic st_out;
      logic empty;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage
`default_nettype wire

// File: src/psd_ctrl.sv
// Sequencer for vertex loads, per-edge evaluation, division and square root.
`default_nettype none
module psd_ctrl #(
   parameter int MAX_VERTICES = 64,
   parameter int AW = $clog2(MAX_VERTICES),
   parameter int NW = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic                 csr_we,
   input  wire logic [6:0]           csr_wdata,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire psd_pkg::status_type  stat,
   output psd_pkg::cmd_type          cmd,
   output logic [AW-1:0]             a_addr,
   output logic [AW-1:0]             b_addr
);

   psd_pkg::state_type state_ff, state_in;
   logic [6:0]                 count_ff;
   logic [AW-1:0]              edge_ff, edge_in;
   logic [psd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       empty_ff, empty_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]              n;
   logic                       last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psd_pkg::ST_IDLE;
         count_ff     <= '0;
         edge_ff      <= '0;
         cnt_ff       <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         cnt_ff       <= cnt_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (int'(count_ff) > MAX_VERTICES) begin
         n = NW'(MAX_VERTICES);
      end else begin
         n = NW'(count_ff);
      end
   end

   assign last      = (edge_ff == AW'(n - NW'(1)));
   assign a_addr    = edge_ff;
   assign b_addr    = last ? '0 : edge_ff + AW'(1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      edge_in   = edge_ff;
      cnt_in    = cnt_ff;
      empty_in  = empty_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.empty = empty_ff;
      case (state_ff)
         psd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == psd_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  edge_in   = '0;
                  if (n == '0) begin
                     empty_in = 1'b1;
                     state_in = psd_pkg::ST_DONE;
                  end else begin
                     empty_in = 1'b0;
                     state_in = psd_pkg::ST_READ;
                  end
               end
            end
         end
         psd_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = psd_pkg::ST_DIFF;
         end
         psd_pkg::ST_DIFF: begin
            cmd.st_diff = 1'b1;
            state_in    = psd_pkg::ST_MUL;
         end
         psd_pkg::ST_MUL: begin
            cmd.st_mul = 1'b1;
            state_in   = psd_pkg::ST_SUM;
         end
         psd_pkg::ST_SUM: begin
            cmd.st_sum = 1'b1;
            state_in   = psd_pkg::ST_T;
         end
         psd_pkg::ST_T: begin
            cmd.st_t = 1'b1;
            cnt_in   = '0;
            if (stat.need_div) begin
               state_in = psd_pkg::ST_DIV;
            end else begin
               state_in = psd_pkg::ST_OFFMUL;
            end
         end
         psd_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + psd_pkg::CNT_W'(1);
            if (cnt_ff == psd_pkg::CNT_W'(psd_pkg::DIV_STEPS - 1)) begin
               state_in = psd_pkg::ST_OFFMUL;
            end
         end
         psd_pkg::ST_OFFMUL: begin
            cmd.st_off = 1'b1;
            state_in   = psd_pkg::ST_DIST;
         end
         psd_pkg::ST_DIST: begin
            cmd.st_d = 1'b1;
            state_in = psd_pkg::ST_SQ;
         end
         psd_pkg::ST_SQ: begin
            cmd.st_sq = 1'b1;
            state_in  = psd_pkg::ST_ACC;
         end
         psd_pkg::ST_ACC: begin
            cmd.st_acc = 1'b1;
            cmd.first  = (edge_ff == '0);
            if (last) begin
               state_in = psd_pkg::ST_RINIT;
            end else begin
               edge_in  = edge_ff + AW'(1);
               state_in = psd_pkg::ST_READ;
            end
         end
         psd_pkg::ST_RINIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = psd_pkg::ST_ROOT;
         end
         psd_pkg::ST_ROOT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + psd_pkg::CNT_W'(1);
            if (cnt_ff == psd_pkg::CNT_W'(psd_pkg::ROOT_STEPS - 1)) begin
               state_in = psd_pkg::ST_DONE;
            end
         end
         psd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.st_out = 1'b1;
               state_in   = psd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.st_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule
`default_nettype wire

// File: src/psd_datapath.sv
// Vertex store and arithmetic for edge distance, winding, division and root.
`default_nettype none
module psd_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int AW = $clog2(MAX_VERTICES),
   parameter int WW = $clog2(MAX_VERTICES) + 2
) (
   input  wire logic                                   clock,
   input  wire psd_pkg::cmd_type                       cmd,
   output psd_pkg::status_type                         stat,
   input  wire logic [AW-1:0]                          a_addr,
   input  wire logic [AW-1:0]                          b_addr,
   input  wire logic [5:0]                             req_vertex_index,
   input  wire logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_y,
   output logic signed [psd_pkg::DIST_W-1:0]           rsp_signed_distance,
   output logic                                        rsp_inside_res,
   output logic                                        rsp_empty_res
);

   localparam int CW = psd_pkg::COORD_WIDTH;

   logic signed [CW-1:0] mem_x [MAX_VERTICES];
   logic signed [CW-1:0] mem_y [MAX_VERTICES];

   logic signed [CW-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [psd_pkg::DIFF_W-1:0] abx_ff, aby_ff, apx_ff, apy_ff;
   logic signed [psd_pkg::PROD_W-1:0] m_len_x_ff, m_len_y_ff, m_dot_x_ff, m_dot_y_ff;
   logic signed [psd_pkg::PROD_W-1:0] m_cr_a_ff, m_cr_b_ff;
   logic signed [psd_pkg::SUM_W-1:0]  len_ff, dot_ff, cross_ff;
   logic [psd_pkg::T_W-1:0]           t_ff;
   logic [psd_pkg::SUM_W-1:0]         rem_ff;
   logic [psd_pkg::SUM_W-1:0]         rem_sh;
   logic signed [psd_pkg::OFFP_W-1:0] offp_x_ff, offp_y_ff;
   logic signed [psd_pkg::OFFP_W-1:0] offr_x, offr_y;
   logic signed [psd_pkg::OFF_W-1:0]  off_x, off_y;
   logic signed [psd_pkg::D_W-1:0]    dx_ff, dy_ff;
   logic signed [psd_pkg::SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [psd_pkg::SQ_W-1:0]          sq;
   logic [psd_pkg::SQ_W-1:0]          best_ff;
   logic signed [WW-1:0]              wind_ff;
   logic [psd_pkg::SQ_W-1:0]          src_ff;
   logic [psd_pkg::ROOT_W+1:0]        srem_ff, srem_sh, trial;
   logic [psd_pkg::ROOT_W-1:0]        root_ff;
   logic signed [psd_pkg::DIST_W-1:0] dist_val;
   logic                              in_poly;

   // vertex store
   always_ff @(posedge clock) begin
      if (cmd.load && (int'(req_vertex_index) < MAX_VERTICES)) begin
         mem_x[AW'(req_vertex_index)] <= req_point_x;
         mem_y[AW'(req_vertex_index)] <= req_point_y;
      end
      if (cmd.rd) begin
         ax_ff <= mem_x[a_addr];
         ay_ff <= mem_y[a_addr];
         bx_ff <= mem_x[b_addr];
         by_ff <= mem_y[b_addr];
      end
   end

   assign stat.need_div = (len_ff != '0) && (dot_ff > psd_pkg::SUM_W'(0)) &&
                          (dot_ff < len_ff);

   assign rem_sh = {rem_ff[psd_pkg::SUM_W-2:0], 1'b0};
   // truncate towards zero
   assign offr_x = offp_x_ff + (offp_x_ff[psd_pkg::OFFP_W-1] ?
                   psd_pkg::OFFP_W'((1 << psd_pkg::FRAC_W) - 1) : '0);
   assign offr_y = offp_y_ff + (offp_y_ff[psd_pkg::OFFP_W-1] ?
                   psd_pkg::OFFP_W'((1 << psd_pkg::FRAC_W) - 1) : '0);
   assign off_x  = psd_pkg::OFF_W'(offr_x >>> psd_pkg::FRAC_W);
   assign off_y  = psd_pkg::OFF_W'(offr_y >>> psd_pkg::FRAC_W);
   assign sq     = psd_pkg::SQ_W'(sqx_ff) + psd_pkg::SQ_W'(sqy_ff);

   assign srem_sh = {srem_ff[psd_pkg::ROOT_W-1:0], src_ff[psd_pkg::SQ_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
      if (cmd.st_diff) begin
         abx_ff <= psd_pkg::DIFF_W'(bx_ff) - psd_pkg::DIFF_W'(ax_ff);
         aby_ff <= psd_pkg::DIFF_W'(by_ff) - psd_pkg::DIFF_W'(ay_ff);
         apx_ff <= psd_pkg::DIFF_W'(px_ff) - psd_pkg::DIFF_W'(ax_ff);
         apy_ff <= psd_pkg::DIFF_W'(py_ff) - psd_pkg::DIFF_W'(ay_ff);
      end
      if (cmd.st_mul) begin
         m_len_x_ff <= abx_ff * abx_ff;
         m_len_y_ff <= aby_ff * aby_ff;
         m_dot_x_ff <= apx_ff * abx_ff;
         m_dot_y_ff <= apy_ff * aby_ff;
         m_cr_a_ff  <= abx_ff * apy_ff;
         m_cr_b_ff  <= aby_ff * apx_ff;
      end
      if (cmd.st_sum) begin
         len_ff   <= psd_pkg::SUM_W'(m_len_x_ff) + psd_pkg::SUM_W'(m_len_y_ff);
         dot_ff   <= psd_pkg::SUM_W'(m_dot_x_ff) + psd_pkg::SUM_W'(m_dot_y_ff);
         cross_ff <= psd_pkg::SUM_W'(m_cr_a_ff) - psd_pkg::SUM_W'(m_cr_b_ff);
      end
      if (cmd.st_t) begin
         rem_ff <= dot_ff;
         if (len_ff == '0 || dot_ff <= psd_pkg::SUM_W'(0) || stat.need_div) begin
            t_ff <= '0;
         end else begin
            t_ff <= psd_pkg::T_W'(1 << psd_pkg::FRAC_W);
         end
      end else if (cmd.div_step) begin
         // restoring divider, one quotient bit a cycle
         if (rem_sh >= len_ff) begin
            rem_ff <= rem_sh - len_ff;
            t_ff   <= {t_ff[psd_pkg::T_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            t_ff   <= {t_ff[psd_pkg::T_W-2:0], 1'b0};
         end
      end
      if (cmd.st_off) begin
         offp_x_ff <= psd_pkg::OFFP_W'(abx_ff * $signed({1'b0, t_ff}));
         offp_y_ff <= psd_pkg::OFFP_W'(aby_ff * $signed({1'b0, t_ff}));
      end
      if (cmd.st_d) begin
         dx_ff <= psd_pkg::D_W'(psd_pkg::D_W'(apx_ff) - psd_pkg::D_W'(off_x));
         dy_ff <= psd_pkg::D_W'(psd_pkg::D_W'(apy_ff) - psd_pkg::D_W'(off_y));
      end
      if (cmd.st_sq) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
      end
      if (cmd.start) begin
         wind_ff <= '0;
      end else if (cmd.st_acc) begin
         if (cmd.first || sq < best_ff) begin
            best_ff <= sq;
         end
         if (ay_ff <= py_ff) begin
            if (by_ff > py_ff && cross_ff > psd_pkg::SUM_W'(0)) begin
               wind_ff <= wind_ff + WW'(1);
            end
         end else if (by_ff <= py_ff && cross_ff < psd_pkg::SUM_W'(0)) begin
            wind_ff <= wind_ff - WW'(1);
         end
      end
      if (cmd.sqrt_init) begin
         src_ff  <= best_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         // two radicand bits a cycle
         src_ff <= {src_ff[psd_pkg::SQ_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= srem_sh - trial;
            root_ff <= {root_ff[psd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[psd_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.st_out) begin
         rsp_signed_distance <= dist_val;
         rsp_inside_res      <= in_poly;
         rsp_empty_res       <= cmd.empty;
      end
   end

   always_comb begin
      in_poly = 1'b0;
      if (cmd.empty) begin
         dist_val = psd_pkg::DIST_MAX;
      end else if (wind_ff != '0) begin
         in_poly = 1'b1;
         if ((psd_pkg::ROOT_W + 1)'(root_ff) >=
             (psd_pkg::ROOT_W + 1)'(1 << (psd_pkg::DIST_W - 1))) begin
            dist_val = psd_pkg::DIST_MIN;
         end else begin
            dist_val = -psd_pkg::DIST_W'(root_ff);
         end
      end else if ((psd_pkg::ROOT_W + 1)'(root_ff) >
                   (psd_pkg::ROOT_W + 1)'(psd_pkg::DIST_MAX)) begin
         dist_val = psd_pkg::DIST_MAX;
      end else begin
         dist_val = psd_pkg::DIST_W'(root_ff);
      end
   end

endmodule
`default_nettype wire

// File: src/polygon_signed_distance.sv
// Top level: signed distance from a point to a stored polygon.
//
// A word on the req channel with req_cmd low writes vertex req_vertex_index
// (req_point_x, req_point_y, Q12.4); it gives no response.
// A word with req_cmd high queries a point and gives one rsp word: the
// distance in Q.4, negative inside, plus inside and empty flags.
// csr_we writes csr_wdata into the vertex count; write it only while idle.
// One item is worked on at a time. A query steps through the edges in turn;
// each edge whose projection falls strictly inside it adds 16 steps of the
// serial divider, one quotient bit a cycle, and the square root is a setup
// step and 18 steps of two radicand bits. The next word is taken the cycle
// after the result is registered. An empty polygon goes from idle straight
// to the done state, with no edge steps.
// Reset clears the vertex count and the control state; vertex slots hold
// nothing defined until loaded. When rsp_ready is low the finished word
// waits in the output register and the next word is still accepted; a
// further query waits at its end until the register is free.
`default_nettype none
module polygon_signed_distance #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_cmd,
   input  wire logic [5:0]                             req_vertex_index,
   input  wire logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [psd_pkg::DIST_W-1:0]           rsp_signed_distance,
   output logic                                        rsp_inside_res,
   output logic                                        rsp_empty_res,
   input  wire logic                                   csr_we,
   input  wire logic [6:0]                             csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);

   psd_pkg::cmd_type    cmd;
   psd_pkg::status_type stat;
   logic [AW-1:0]       a_addr, b_addr;

   psd_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .a_addr    (a_addr),
      .b_addr    (b_addr)
   );

   psd_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .stat                (stat),
      .a_addr              (a_addr),
      .b_addr              (b_addr),
      .req_vertex_index    (req_vertex_index),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .rsp_signed_distance (rsp_signed_distance),
      .rsp_inside_res      (rsp_inside_res),
      .rsp_empty_res       (rsp_empty_res)
   );

endmodule
`default_nettype wire

// File: bench/tb_polygon_signed_distance.sv
// Testbench for polygon_signed_distance: random polygons, queries and stalls.
`default_nettype none
module tb_polygon_signed_distance;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [psd_pkg::DIST_W-1:0] dist_q;
      logic                              in_poly;
      logic                              empty;
   } dist_word_type;

   class distance_board;
      longint        vx[64];
      longint        vy[64];
      int            n_verts;
      dist_word_type owed[$];
      int            errors, queries, loads, insides, empties;

      function longint unsigned isqrt(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unsigned edge_sq(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
         longint abx, aby, apx, apy, len, dot, t, dx, dy;
         abx = bx - ax; aby = by - ay;
         apx = px - ax; apy = py - ay;
         len = abx * abx + aby * aby;
         dx = apx; dy = apy;
         if (len != 0) begin
            dot = apx * abx + apy * aby;
            if (dot <= 0) t = 0;
            else if (dot >= len) t = 65536;
            else t = (dot * 65536) / len;
            dx = apx - (abx * t) / 65536;
            dy = apy - (aby * t) / 65536;
         end
         return dx * dx + dy * dy;
      endfunction

      function void note_word(logic cmd, logic [5:0] idx, logic signed [15:0] x,
                              logic signed [15:0] y);
         dist_word_type w;
         int n, j, wind;
         longint unsigned sq, best;
         longint px, py, cr, d;
         if (cmd == psd_pkg::CMD_LOAD) begin
            vx[idx] = x; vy[idx] = y;
            loads++;
            return;
         end
         queries++;
         n = (n_verts > 64) ? 64 : n_verts;
         if (n == 0) begin
            w.dist_q = psd_pkg::DIST_MAX; w.in_poly = 0; w.empty = 1;
            empties++;
            owed.insert(owed.size(), w);
            return;
         end
         px = x; py = y; wind = 0; best = 0;
         for (int i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            sq = edge_sq(vx[i], vy[i], vx[j], vy[j], px, py);
            cr = (vx[j] - vx[i]) * (py - vy[i]) - (vy[j] - vy[i]) * (px - vx[i]);
            if (i == 0 || sq < best) best = sq;
            if (vy[i] <= py) begin
               if (vy[j] > py && cr > 0) wind++;
            end else begin
               if (vy[j] <= py && cr < 0) wind--;
            end
         end
         d = isqrt(best);
         w.in_poly = (wind != 0);
         w.empty   = 0;
         if (w.in_poly) begin
            d = -d;
            if (d < -131072) d = -131072;
            insides++;
         end else if (d > 131071) begin
            d = 131071;
         end
         w.dist_q = psd_pkg::DIST_W'(d);
         owed.insert(owed.size(), w);
      endfunction

      function void check_word(logic signed [psd_pkg::DIST_W-1:0] act_dist, logic act_in,
                               logic act_empty);
         dist_word_type w;
         if (owed.size() == 0) begin
            $display("%0t: unexpected rsp word dist=%0d inside=%0b empty=%0b",
                     $time, act_dist, act_in, act_empty);
            errors++;
            return;
         end
         w = owed.pop_front();
         if (act_dist !== w.dist_q) begin
            $display("%0t: distance expected %0d actual %0d", $time, w.dist_q, act_dist);
            errors++;
         end
         if (act_in !== w.in_poly) begin
            $display("%0t: inside expected %0b actual %0b", $time, w.in_poly, act_in);
            errors++;
         end
         if (act_empty !== w.empty) begin
            $display("%0t: empty expected %0b actual %0b", $time, w.empty, act_empty);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_cmd;
   logic [5:0] req_vertex_index;
   logic signed [psd_pkg::COORD_WIDTH-1:0] req_point_x, req_point_y;
   logic rsp_valid, rsp_ready;
   logic signed [psd_pkg::DIST_W-1:0] rsp_signed_distance;
   logic rsp_inside_res, rsp_empty_res;
   logic csr_we;
   logic [6:0] csr_wdata;

   distance_board board;
   bit  calm, hold_req;
   int  sent, max_count;

   polygon_signed_distance DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_vertex_index(req_vertex_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_signed_distance(rsp_signed_distance), .rsp_inside_res(rsp_inside_res),
      .rsp_empty_res(rsp_empty_res),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("polygon_signed_distance verification failed");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_signed_distance, rsp_inside_res, rsp_empty_res);

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic send_word(logic cmd, logic [5:0] idx, logic signed [15:0] x,
                            logic signed [15:0] y);
      int gap;
      gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_cmd <= cmd; req_vertex_index <= idx;
      req_point_x <= x; req_point_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(cmd, idx, x, y);
      sent++;
   endtask

   // drain: all results in, then a pause for a trailing load
   task automatic settle();
      req_valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_count(int v);
      settle();
      csr_we <= 1; csr_wdata <= 7'(v);
      @(posedge clock);
      csr_we <= 0;
      board.n_verts = v;
      if (v > max_count) max_count = v;
   endtask

   function automatic logic signed [15:0] coord(int span);
      if (span >= 32768) return 16'($urandom);
      return 16'($urandom_range(2 * span) - span);
   endfunction

   initial begin
      int n, span, nq;
      board = new();
      reset = 1; req_valid = 0; req_cmd = 0; req_vertex_index = 0;
      req_point_x = 0; req_point_y = 0; csr_we = 0; csr_wdata = 0;
      calm = 0; hold_req = 0; sent = 0; max_count = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty polygon
      send_word(psd_pkg::CMD_QUERY, 0, 16'sh7fff, 16'sh8000);
      set_count(0);
      send_word(psd_pkg::CMD_QUERY, 6'h3f, 16'sh8000, 16'sh7fff);
      // square of side 200 units
      send_word(psd_pkg::CMD_LOAD, 0, -1600, -1600);
      send_word(psd_pkg::CMD_LOAD, 1, 1600, -1600);
      send_word(psd_pkg::CMD_LOAD, 2, 1600, 1600);
      send_word(psd_pkg::CMD_LOAD, 3, -1600, 1600);
      send_word(psd_pkg::CMD_LOAD, 4, -1600, 1600);
      set_count(4);
      send_word(psd_pkg::CMD_QUERY, 0, 0, 0);
      send_word(psd_pkg::CMD_QUERY, 0, 16'sh7fff, 16'sh7fff);
      send_word(psd_pkg::CMD_QUERY, 0, 16'sh8000, 16'sh8000);
      send_word(psd_pkg::CMD_QUERY, 0, 1600, 1600);
      send_word(psd_pkg::CMD_QUERY, 0, 1600, 7);
      send_word(psd_pkg::CMD_QUERY, 0, 1599, -3);
      // repeated vertex gives a zero-length edge
      set_count(5);
      send_word(psd_pkg::CMD_QUERY, 0, -1700, 1650);
      send_word(psd_pkg::CMD_QUERY, 0, 5, -5);

      for (int ph = 0; sent < 1200; ph++) begin
         case ($urandom_range(9))
            0:       n = 0;
            1:       n = $urandom_range(1, 2);
            2:       n = 64;
            default: n = $urandom_range(3, 8);
         endcase
         case ($urandom_range(3))
            0:       span = 32768;
            1:       span = 4000;
            default: span = 300;
         endcase
         calm = (ph >= 20 && ph < 28);
         settle();
         for (int i = 0; i < n; i++)
            send_word(psd_pkg::CMD_LOAD, 6'(i), coord(span), coord(span));
         if (n == 64) begin
            case ($urandom_range(2))
               0:       set_count(64);
               1:       set_count($urandom_range(65, 126));
               default: set_count(127);
            endcase
            nq = 6;
         end else begin
            set_count(n);
            nq = $urandom_range(8, 30);
         end
         if (ph == 10) hold_req = 1;
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(9) == 0) begin
               // stray load: any slot, polygon slots included
               send_word(psd_pkg::CMD_LOAD, 6'($urandom_range(63)), coord(32768),
                         coord(32768));
            end else begin
               send_word(psd_pkg::CMD_QUERY, 6'($urandom),
                         coord($urandom_range(3) == 0 ? 32768 : span + 50),
                         coord($urandom_range(3) == 0 ? 32768 : span + 50));
            end
         end
      end
      calm = 0;
      req_valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d loads and %0d queries (%0d inside, %0d empty); count up to %0d.",
               board.loads, board.queries, board.insides, board.empties, max_count);
      if (board.errors == 0)
         $display("polygon_signed_distance verification clean");
      else
         $display("polygon_signed_distance verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
src/psd_pkg.sv
src/psd_ctrl.sv
src/psd_datapath.sv
src/polygon_signed_distance.sv
bench/tb_polygon_signed_distance.sv
